[design/rgb_lut1d_linear_interp_top_assert.svh]
// Assertion macros for the curve lookup block.
`ifndef RGB_LUT1D_LINEAR_INTERP_TOP_ASSERT_SVH
`define RGB_LUT1D_LINEAR_INTERP_TOP_ASSERT_SVH

// Same-cycle implication, masked during reset.
`define RGBLUT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked during reset.
`define RGBLUT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/rgblut_pkg.sv]
package rgblut_pkg;

    // Curve storage
    localparam int CURVE_DEPTH_DEF = 4096;
    localparam int NUM_CHAN        = 3;

    // Field widths
    localparam int ENTRY_W  = 12;
    localparam int VAL_W    = 16;
    localparam int SAMPLE_W = 24;
    localparam int FRAC_W   = 16;
    localparam int SIZE_W   = 13;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 13'd4096;

    // Stream packing
    localparam int S_TDATA_W = 128;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 72;

    localparam int ENTRY_IDX_LSB = 0;
    localparam int ENTRY_VAL_LSB = 12;
    localparam int RED_LSB       = 28;
    localparam int ALPHA_LSB     = 100;

    localparam int ACT_BIT = 0;
    localparam int SEL_LSB = 1;
    localparam int SEL_MSB = 2;

    // Action codes
    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_PIXEL = 1'b1;

    // Curve select codes
    localparam logic [1:0] SEL_RED   = 2'd0;
    localparam logic [1:0] SEL_GREEN = 2'd1;
    localparam logic [1:0] SEL_BLUE  = 2'd2;

    localparam logic [1:0] CHAN_SEL [NUM_CHAN] = '{SEL_RED, SEL_GREEN, SEL_BLUE};

    // Register file
    localparam int PADDR_W = 3;
    localparam logic [PADDR_W-3:0] REG_CURVE_SIZE = 1'b0;

    // Result queue
    localparam int FIFO_DEPTH = 8;

    typedef struct packed {
        logic [SAMPLE_W-1:0] alpha;
        logic [VAL_W-1:0]    blue;
        logic [VAL_W-1:0]    green;
        logic [VAL_W-1:0]    red;
        logic                frame_end;
    } result_t;

endpackage

[design/rgb_lut1d_linear_interp_top.sv]
// Per-channel 1D curve lookup with linear interpolation for RGBA pixels.
// Input stream (s_*): one beat is either a curve load (tuser action = load)
// that writes one 16-bit entry into the red, green or blue curve, or a pixel
// (action = pixel) carrying signed Q8.16 red, green, blue and alpha samples;
// tlast marks the last pixel of a frame. Loads produce no output beat.
// Output stream (m_*): one beat per pixel with the three interpolated 16-bit
// curve values, alpha copied and tlast copied.
// APB port: register curve_size at byte address 0 sets the entries in use;
// write it only while no pixel is in flight.
// Throughput: one beat per cycle, loads and pixels mixed freely. Each curve
// sits in a RAM with one write port and two registered read ports, so the
// lower and upper neighbor are fetched in the same cycle.
// Pipeline: an accepted pixel goes through multiply, clamp and RAM read,
// interpolation multiply and add into the queue, then shows on m_tvalid.
// Stall: results land in an 8-entry queue; s_tready drops once eight pixels
// are outstanding, so the pipeline itself never stops.
// Reset: curve_size returns to 4096, the queue empties; curve contents are
// kept and stay undefined until loaded.
`include "rgb_lut1d_linear_interp_top_assert.svh"

module rgb_lut1d_linear_interp_top #(
    parameter int CURVE_DEPTH = rgblut_pkg::CURVE_DEPTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // APB register port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rgblut_pkg::PADDR_W-1:0]      paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    // Input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // entry_index[11:0], entry_value[27:12], red_in[51:28], green_in[75:52],
    // blue_in[99:76], alpha_in[123:100], zero[127:124]
    input  logic [rgblut_pkg::S_TDATA_W-1:0]    s_tdata,
    // action[0], table_select[2:1]
    input  logic [rgblut_pkg::S_TUSER_W-1:0]    s_tuser,
    input  logic                                s_tlast,
    // Output stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // red_out[15:0], green_out[31:16], blue_out[47:32], alpha_out[71:48]
    output logic [rgblut_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                                m_tlast
);

    import rgblut_pkg::*;

    localparam int IDX_W  = (CURVE_DEPTH > 1) ? $clog2(CURVE_DEPTH) : 1;
    localparam int PROD_W = SAMPLE_W + IDX_W + 1;
    localparam int XC_W   = IDX_W + FRAC_W;
    localparam int AW_EXT = (IDX_W > ENTRY_W) ? IDX_W : ENTRY_W;
    localparam int DIFF_W = VAL_W + 1;
    localparam int ACC_W  = 2 * DIFF_W;
    localparam int PTR_W  = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W  = $clog2(FIFO_DEPTH + 1);

    // ------------------------------------------------------------------
    // Register port
    // ------------------------------------------------------------------
    logic [SIZE_W-1:0] curve_size_reg;
    logic              cfg_wr;
    logic              cfg_hit;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_hit = (paddr[PADDR_W-1:2] == REG_CURVE_SIZE);
    assign prdata  = cfg_hit ? 32'(curve_size_reg) : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            curve_size_reg <= SIZE_RESET;
        end else if (cfg_wr && cfg_hit) begin
            curve_size_reg <= pwdata[SIZE_W-1:0];
        end
    end

    // Clamp the size into 2 .. CURVE_DEPTH and form the last index.
    logic [31:0]      size_clamp;
    logic [31:0]      last_wide;
    logic [IDX_W-1:0] last_now;

    always_comb begin
        if (32'(curve_size_reg) < 32'd2) begin
            size_clamp = 32'd2;
        end else if (32'(curve_size_reg) > 32'(CURVE_DEPTH)) begin
            size_clamp = 32'(CURVE_DEPTH);
        end else begin
            size_clamp = 32'(curve_size_reg);
        end
        last_wide = size_clamp - 32'd1;
        last_now  = last_wide[IDX_W-1:0];
    end

    // ------------------------------------------------------------------
    // Input decode
    // ------------------------------------------------------------------
    logic              s_acc;
    logic              pix_acc;
    logic              load_acc;
    logic [1:0]        load_sel;
    logic [ENTRY_W-1:0] entry_index;
    logic [VAL_W-1:0]  entry_value;
    logic [AW_EXT-1:0] entry_ext;
    logic [IDX_W-1:0]  load_addr;
    logic [CNT_W-1:0]  pend_cnt_reg;

    assign s_tready    = (pend_cnt_reg < CNT_W'(FIFO_DEPTH));
    assign s_acc       = s_tvalid & s_tready;
    assign pix_acc     = s_acc & (s_tuser[ACT_BIT] == ACT_PIXEL);
    assign load_sel    = s_tuser[SEL_MSB:SEL_LSB];
    assign entry_index = s_tdata[ENTRY_IDX_LSB +: ENTRY_W];
    assign entry_value = s_tdata[ENTRY_VAL_LSB +: VAL_W];
    assign entry_ext   = AW_EXT'(entry_index);
    assign load_addr   = entry_ext[IDX_W-1:0];
    // Drop loads past the end of the curve storage.
    assign load_acc    = s_acc & (s_tuser[ACT_BIT] == ACT_LOAD)
                       & (32'(entry_index) < 32'(CURVE_DEPTH));

    // ------------------------------------------------------------------
    // Pipeline control and pass-through fields
    // ------------------------------------------------------------------
    logic                p1_vld_reg, p2_vld_reg, p3_vld_reg;
    logic [IDX_W-1:0]    p1_last_reg;
    logic [SAMPLE_W-1:0] p1_alpha_reg, p2_alpha_reg, p3_alpha_reg;
    logic                p1_fe_reg, p2_fe_reg, p3_fe_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_vld_reg <= 1'b0;
            p2_vld_reg <= 1'b0;
            p3_vld_reg <= 1'b0;
        end else begin
            p1_vld_reg <= pix_acc;
            p2_vld_reg <= p1_vld_reg;
            p3_vld_reg <= p2_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pix_acc) begin
            p1_last_reg  <= last_now;
            p1_alpha_reg <= s_tdata[ALPHA_LSB +: SAMPLE_W];
            p1_fe_reg    <= s_tlast;
        end
        p2_alpha_reg <= p1_alpha_reg;
        p2_fe_reg    <= p1_fe_reg;
        p3_alpha_reg <= p2_alpha_reg;
        p3_fe_reg    <= p2_fe_reg;
    end

    // ------------------------------------------------------------------
    // Per-channel datapath
    // ------------------------------------------------------------------
    logic [VAL_W-1:0] chan_res [NUM_CHAN];

    for (genvar c = 0; c < NUM_CHAN; c++) begin : g_chan
        logic signed [SAMPLE_W-1:0] sample;
        logic signed [PROD_W-1:0]   x_next;
        logic signed [PROD_W-1:0]   p1_x_reg;
        logic signed [PROD_W-1:0]   top_s;
        logic [XC_W-1:0]            top_u;
        logic [XC_W-1:0]            x_clamp;
        logic [IDX_W-1:0]           idx;
        logic [IDX_W-1:0]           nxt;
        logic                       we;
        logic [VAL_W-1:0]           lo_rd, hi_rd;
        logic [FRAC_W-1:0]          p2_frac_reg;
        logic signed [DIFF_W-1:0]   diff;
        logic signed [ACC_W-1:0]    prod_next;
        logic signed [ACC_W-1:0]    p3_prod_reg;
        logic [VAL_W-1:0]           p3_lo_reg;
        logic signed [ACC_W-1:0]    acc;

        assign sample = s_tdata[RED_LSB + c * SAMPLE_W +: SAMPLE_W];
        // Scale by the last index: exact Q.16 position.
        assign x_next = PROD_W'($signed(sample) * $signed({1'b0, last_now}));

        always_ff @(posedge aclk) begin
            if (pix_acc) begin
                p1_x_reg <= x_next;
            end
        end

        // Clamp into 0 .. last, split into index and fraction.
        assign top_u = {p1_last_reg, FRAC_W'(0)};
        assign top_s = $signed(PROD_W'(top_u));

        always_comb begin
            if (p1_x_reg[PROD_W-1]) begin
                x_clamp = '0;
            end else if (p1_x_reg > top_s) begin
                x_clamp = top_u;
            end else begin
                x_clamp = p1_x_reg[XC_W-1:0];
            end
            idx = x_clamp[XC_W-1:FRAC_W];
            nxt = (idx == p1_last_reg) ? idx : IDX_W'(idx + 1'b1);
        end

        assign we = load_acc & (load_sel == CHAN_SEL[c]);

        rgblut_ram #(
            .DATA_W (VAL_W),
            .DEPTH  (CURVE_DEPTH)
        ) u_curve (
            .clk     (aclk),
            .we      (we),
            .waddr   (load_addr),
            .wdata   (entry_value),
            .raddr_a (idx),
            .rdata_a (lo_rd),
            .raddr_b (nxt),
            .rdata_b (hi_rd)
        );

        always_ff @(posedge aclk) begin
            p2_frac_reg <= x_clamp[FRAC_W-1:0];
        end

        // Slope times fraction.
        assign diff      = $signed({1'b0, hi_rd}) - $signed({1'b0, lo_rd});
        assign prod_next = diff * $signed({1'b0, p2_frac_reg});

        always_ff @(posedge aclk) begin
            p3_prod_reg <= prod_next;
            p3_lo_reg   <= lo_rd;
        end

        // Lower entry in Q.16 plus the step, truncate the fraction.
        assign acc = $signed({1'b0, 1'b0, p3_lo_reg, FRAC_W'(0)}) + p3_prod_reg;
        assign chan_res[c] = acc[FRAC_W +: VAL_W];
    end

    // ------------------------------------------------------------------
    // Result queue
    // ------------------------------------------------------------------
    result_t          fifo_mem_reg [FIFO_DEPTH];
    result_t          fifo_head;
    result_t          fifo_in;
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] fifo_cnt_reg;
    logic             fifo_wr, fifo_rd;

    assign fifo_wr = p3_vld_reg;
    assign fifo_rd = m_tvalid & m_tready;

    assign fifo_in.alpha     = p3_alpha_reg;
    assign fifo_in.blue      = chan_res[2];
    assign fifo_in.green     = chan_res[1];
    assign fifo_in.red       = chan_res[0];
    assign fifo_in.frame_end = p3_fe_reg;

    always_ff @(posedge aclk) begin
        if (fifo_wr) begin
            fifo_mem_reg[wr_ptr_reg] <= fifo_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fifo_cnt_reg <= '0;
            pend_cnt_reg <= '0;
        end else begin
            if (fifo_wr) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                    : wr_ptr_reg + 1'b1;
            end
            if (fifo_rd) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                    : rd_ptr_reg + 1'b1;
            end
            case ({fifo_wr, fifo_rd})
                2'b10:   fifo_cnt_reg <= fifo_cnt_reg + 1'b1;
                2'b01:   fifo_cnt_reg <= fifo_cnt_reg - 1'b1;
                default: fifo_cnt_reg <= fifo_cnt_reg;
            endcase
            // Hold a credit for every pixel from accept until its beat leaves.
            case ({pix_acc, fifo_rd})
                2'b10:   pend_cnt_reg <= pend_cnt_reg + 1'b1;
                2'b01:   pend_cnt_reg <= pend_cnt_reg - 1'b1;
                default: pend_cnt_reg <= pend_cnt_reg;
            endcase
        end
    end

    assign fifo_head = fifo_mem_reg[rd_ptr_reg];
    assign m_tvalid  = (fifo_cnt_reg != '0);
    assign m_tdata   = {fifo_head.alpha, fifo_head.blue, fifo_head.green, fifo_head.red};
    assign m_tlast   = fifo_head.frame_end;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `RGBLUT_ASSERT_NOW(a_credit_bound, aclk, aresetn, 1'b1, pend_cnt_reg <= CNT_W'(FIFO_DEPTH), "outstanding pixels exceed queue depth")
    `RGBLUT_ASSERT_NOW(a_queue_in_credit, aclk, aresetn, 1'b1, fifo_cnt_reg <= pend_cnt_reg, "queue holds more beats than credits")
    `RGBLUT_ASSERT_NOW(a_no_overflow, aclk, aresetn, fifo_wr && !fifo_rd, fifo_cnt_reg != CNT_W'(FIFO_DEPTH), "write into full result queue")
    `RGBLUT_ASSERT_NEXT(a_pixel_enters, aclk, aresetn, pix_acc, p1_vld_reg, "accepted pixel missing from first stage")

endmodule

[design/rgblut_ram.sv]
module rgblut_ram #(
    parameter int DATA_W = 16,
    parameter int DEPTH  = 4096,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr_a,
    output logic [DATA_W-1:0] rdata_a,
    input  logic [ADDR_W-1:0] raddr_b,
    output logic [DATA_W-1:0] rdata_b
);

    logic [DATA_W-1:0] mem_reg [DEPTH];

    // Read-first: a read and a write at the same edge return the old word.
    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_a <= mem_reg[raddr_a];
        rdata_b <= mem_reg[raddr_b];
    end

endmodule
